FILE: rtl/hdlc_async_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HDLC frame receiver
// Clocked property checks; they compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HDLC_ASYNC_FRAME_RECEIVER_ASSERT_SVH
`define HDLC_ASYNC_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// check under reset gating
`define HAFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check at every edge, reset included
`define HAFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define HAFR_ASSERT(lbl, prop, msg)
`define HAFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/hafr_pkg.sv
// ----------------------------------------------------------------------------
// HDLC frame receiver package
// Codes, widths, result record and the byte-wide PPP FCS update.
// ----------------------------------------------------------------------------
package hafr_pkg;

  // width of the frame byte counter
  localparam int unsigned LENGTH_WIDTH = 16;

  // framing octets
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // check field modes
  localparam logic [1:0] FCS_NONE = 2'd0;
  localparam logic [1:0] FCS_16   = 2'd1;
  localparam logic [1:0] FCS_32   = 2'd2;

  // residues of a good frame, start values and polynomials
  localparam logic [31:0] FCS16_GOOD = 32'h0000_F0B8;
  localparam logic [31:0] FCS32_GOOD = 32'hDEBB_20E3;
  localparam logic [31:0] FCS16_INIT = 32'h0000_FFFF;
  localparam logic [31:0] FCS32_INIT = 32'hFFFF_FFFF;
  localparam logic [15:0] FCS16_POLY = 16'h8408;
  localparam logic [31:0] FCS32_POLY = 32'hEDB8_8320;

  // configuration register indexes
  localparam logic [1:0] CFG_FCS_MODE    = 2'd0;
  localparam logic [1:0] CFG_UID_ENABLE  = 2'd1;
  localparam logic [1:0] CFG_BUFFER_SIZE = 2'd2;

  localparam logic [1:0]  FCS_MODE_RST    = FCS_16;
  localparam logic [15:0] BUFFER_SIZE_RST = 16'd256;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UID  = 2'd1,
    PH_DATA = 2'd2
  } rx_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOF  = 2'd1,
    KIND_OOS  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FAILED   = 2'd1,
    ST_TOO_LARGE = 2'd2
  } status_e;

  // one result transaction
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    status_e     status;
    logic [15:0] frame_uid;
  } result_t;

  // byte-wide FCS update, LSB first; other modes leave the register alone
  function automatic logic [31:0] fcs_update(logic [1:0] mode, logic [31:0] crc,
                                             logic [7:0] b);
    logic [15:0] c16;
    logic [31:0] c32;
    logic [31:0] res;
    c16 = crc[15:0] ^ {8'h00, b};
    c32 = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c16 = c16[0] ? ((c16 >> 1) ^ FCS16_POLY) : (c16 >> 1);
      c32 = c32[0] ? ((c32 >> 1) ^ FCS32_POLY) : (c32 >> 1);
    end
    if (mode == FCS_16) begin
      res = {16'h0000, c16};
    end else if (mode == FCS_32) begin
      res = c32;
    end else begin
      res = crc;
    end
    return res;
  endfunction

endpackage

FILE: rtl/hdlc_async_frame_receiver.sv
// ----------------------------------------------------------------------------
// HDLC asynchronous frame receiver
// Flag/escape deframer with optional UID and PPP FCS-16/FCS-32 check.
// ----------------------------------------------------------------------------
// Takes one line byte per cycle while in_stall_o is low and gives at most one
// result per byte: a decoded data byte with its buffer index, an end-of-frame
// report (length, status, UID), or an out-of-sync byte seen between frames.
// An input register and a result register sit around one decode stage whose
// depth is set by the byte-wide CRC update. The input register doubles as a
// skid slot, so one byte is still taken while a result waits downstream.
// Configuration is written through a plain write port and must only change
// while the receiver is quiet; fcs_mode is used per byte, while the FCS start
// value and the UID choice are latched when a frame opens. There is no
// clearing pass after reset.
module hdlc_async_frame_receiver
  import hafr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // line byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_length_o,
  output logic [1:0]  status_o,
  output logic [15:0] frame_uid_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned ExtW = 33;

  // configuration registers
  logic [1:0]  fcs_mode_q;
  logic        uid_enable_q;
  logic [15:0] buffer_size_q;

  // input (skid) register
  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;

  // receiver state
  rx_phase_e             phase_q, phase_d;
  logic [7:0]            prev_q, prev_d;
  logic [15:0]           uid_acc_q, uid_acc_d;
  logic [4:0]            uid_cnt_q, uid_cnt_d;
  logic [LENGTH_WIDTH-1:0] count_q, count_d;
  logic [31:0]           check_q, check_d;

  // result register
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;
  logic        res_vld;

  // decode helpers
  logic            proc;
  logic [7:0]      dec_byte;
  logic [ExtW-1:0] cnt_ext;
  logic [ExtW-1:0] len_ext;
  logic [2:0]      nfcs;
  logic            fcs_good;
  logic [4:0]      uid_cnt_nxt;

  // ---------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_mode_q    <= FCS_MODE_RST;
      uid_enable_q  <= 1'b0;
      buffer_size_q <= BUFFER_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FCS_MODE:    fcs_mode_q    <= cfg_data_i[1:0];
        CFG_UID_ENABLE:  uid_enable_q  <= cfg_data_i[0];
        CFG_BUFFER_SIZE: buffer_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: decode when a byte is held and the result slot is free or being drained
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  always_comb begin
    in_valid_d = in_valid_q;
    if (proc) in_valid_d = 1'b0;
    if (in_valid_i && !in_stall_o) in_valid_d = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Decode stage
  assign cnt_ext  = ExtW'(count_q);
  assign dec_byte = (prev_q == ESC_BYTE) ? (in_byte_q ^ ESC_XOR) : in_byte_q;
  assign nfcs     = (fcs_mode_q == FCS_16) ? 3'd2 : ((fcs_mode_q == FCS_32) ? 3'd4 : 3'd0);
  assign len_ext  = cnt_ext - ExtW'(nfcs);
  assign uid_cnt_nxt = uid_cnt_q + 5'd8;

  always_comb begin
    if (fcs_mode_q == FCS_16)      fcs_good = (check_q == FCS16_GOOD);
    else if (fcs_mode_q == FCS_32) fcs_good = (check_q == FCS32_GOOD);
    else                           fcs_good = 1'b1;
  end

  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    uid_acc_d = uid_acc_q;
    uid_cnt_d = uid_cnt_q;
    count_d   = count_q;
    check_d   = check_q;
    res_vld   = 1'b0;
    res_d     = '0;
    if (proc) begin
      if (phase_q == PH_IDLE) begin
        if (in_byte_q != FLAG_BYTE) begin
          // noise between frames
          res_vld        = 1'b1;
          res_d.kind     = KIND_OOS;
          res_d.data_byte = in_byte_q;
        end else begin
          // opening flag
          count_d   = '0;
          prev_d    = FLAG_BYTE;
          uid_acc_d = '0;
          uid_cnt_d = '0;
          if (fcs_mode_q == FCS_16)      check_d = FCS16_INIT;
          else if (fcs_mode_q == FCS_32) check_d = FCS32_INIT;
          phase_d = uid_enable_q ? PH_UID : PH_DATA;
        end
      end else if (in_byte_q == FLAG_BYTE) begin
        // closing flag; a repeated flag is dropped
        if (prev_q != FLAG_BYTE) begin
          phase_d    = PH_IDLE;
          res_vld    = 1'b1;
          res_d.kind = KIND_EOF;
          if (uid_enable_q) res_d.frame_uid = uid_acc_q;
          if (cnt_ext < ExtW'(nfcs)) begin
            res_d.status = ST_FAILED;
          end else begin
            res_d.frame_length = (len_ext > ExtW'(16'hFFFF)) ? 16'hFFFF : len_ext[15:0];
            if (len_ext >= ExtW'(buffer_size_q)) res_d.status = ST_TOO_LARGE;
            else if (!fcs_good)                  res_d.status = ST_FAILED;
            else                                 res_d.status = ST_OK;
          end
        end
      end else if (in_byte_q == ESC_BYTE) begin
        prev_d = ESC_BYTE;
      end else begin
        prev_d = in_byte_q;
        if (phase_q == PH_UID) begin
          // little-endian UID, low byte first
          if (uid_cnt_q[3]) uid_acc_d = uid_acc_q | {dec_byte, 8'h00};
          else              uid_acc_d = uid_acc_q | {8'h00, dec_byte};
          uid_cnt_d = uid_cnt_nxt;
          if (uid_cnt_nxt >= 5'd16) phase_d = PH_DATA;
        end else begin
          if (cnt_ext < ExtW'(buffer_size_q)) begin
            res_vld          = 1'b1;
            res_d.kind       = KIND_DATA;
            res_d.data_byte  = dec_byte;
            res_d.byte_index = cnt_ext[15:0];
          end
          if (count_q != {LENGTH_WIDTH{1'b1}}) count_d = count_q + LENGTH_WIDTH'(1);
        end
        check_d = fcs_update(fcs_mode_q, check_q, dec_byte);
      end
    end
  end

  // result slot: drained by the sink, refilled by the decode stage
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (proc) out_valid_d = res_vld;
  end

  // ---------------------------------------------------------------------
  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      prev_q      <= '0;
      uid_acc_q   <= '0;
      uid_cnt_q   <= '0;
      count_q     <= '0;
      check_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      prev_q      <= prev_d;
      uid_acc_q   <= uid_acc_d;
      uid_cnt_q   <= uid_cnt_d;
      count_q     <= count_d;
      check_q     <= check_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_byte_q <= rx_byte_i;
    if (proc) res_q <= res_d;
  end

  // ---------------------------------------------------------------------
  // Outputs
  assign out_valid_o    = out_valid_q;
  assign kind_o         = res_q.kind;
  assign data_byte_o    = res_q.data_byte;
  assign byte_index_o   = res_q.byte_index;
  assign frame_length_o = res_q.frame_length;
  assign status_o       = res_q.status;
  assign frame_uid_o    = res_q.frame_uid;

  // ---------------------------------------------------------------------
  // Assertions
`include "hdlc_async_frame_receiver_assert.svh"

  // input only backs up when a held result is blocked
  `HAFR_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a blocked result")
  // stored data bytes stay inside the buffer
  `HAFR_ASSERT(a_index_range, (out_valid_o && kind_o == KIND_DATA) |-> (byte_index_o < buffer_size_q), "data byte index beyond buffer")
  // an opening flag always leaves the idle phase
  `HAFR_ASSERT(a_open_frame, (proc && phase_q == PH_IDLE && in_byte_q == FLAG_BYTE) |=> (phase_q != PH_IDLE), "flag did not open a frame")
  // a decode step never overruns an undrained result
  `HAFR_ASSERT(a_no_overrun, (out_valid_q && out_stall_i) |=> ($stable(res_q) && out_valid_q), "result changed while blocked")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC frame receiver testbench
// Drives line bytes with random gaps against random result stalls. Every
// accepted byte is run through a local deframer and FCS predictor; each
// result transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import hafr_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1450;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] byte_index_o;
  logic [15:0] frame_length_o;
  logic [1:0]  status_o;
  logic [15:0] frame_uid_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  hdlc_async_frame_receiver uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .status_o       (status_o),
    .frame_uid_o    (frame_uid_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // register shadow
  logic [1:0]  fcs_mode_q  = FCS_MODE_RST;
  logic        uid_en_q    = 1'b0;
  logic [15:0] buf_size_q  = BUFFER_SIZE_RST;

  // deframer state
  rx_phase_e   rx_phase    = PH_IDLE;
  logic [7:0]  last_byte   = 8'h00;
  logic [15:0] uid_acc     = 16'h0000;
  logic [4:0]  uid_bits    = 5'd0;
  logic [15:0] frame_bytes = 16'h0000;
  logic [31:0] fcs_acc     = 32'h0;

  result_t     decoded_q[$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned quiet_cycles = 0;
  bit          sender_gaps = 1'b1;
  bit          result_stalls = 1'b1;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // byte-wide PPP FCS step, reflected, one bit at a time
  function automatic logic [31:0] fcs_step(logic [1:0] mode, logic [31:0] acc, logic [7:0] d);
    logic [31:0] r;
    r = acc;
    if (mode == FCS_16) begin
      r = {16'h0000, acc[15:0] ^ {8'h00, d}};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ {16'h0000, FCS16_POLY}) : (r >> 1);
    end else if (mode == FCS_32) begin
      r = acc ^ {24'h0, d};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ FCS32_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // expected outcome of one line byte; updates the local deframer state
  task automatic decode_line_byte(input logic [7:0] b);
    result_t     res;
    logic [7:0]  d;
    logic [15:0] fcs_len;
    logic [15:0] len;
    logic        fcs_ok;
    res = '0;
    if (rx_phase == PH_IDLE) begin
      if (b != FLAG_BYTE) begin
        res.kind = KIND_OOS;
        res.data_byte = b;
        decoded_q.push_back(res);
      end else begin
        // opening flag: FCS start value and UID choice taken here
        frame_bytes = 16'h0000;
        last_byte = FLAG_BYTE;
        uid_acc = 16'h0000;
        uid_bits = 5'd0;
        if (fcs_mode_q == FCS_16) fcs_acc = FCS16_INIT;
        else if (fcs_mode_q == FCS_32) fcs_acc = FCS32_INIT;
        rx_phase = uid_en_q ? PH_UID : PH_DATA;
      end
    end else if (b == FLAG_BYTE) begin
      // back-to-back flags are skipped, otherwise the frame closes
      if (last_byte != FLAG_BYTE) begin
        rx_phase = PH_IDLE;
        fcs_len = (fcs_mode_q == FCS_16) ? 16'd2 : ((fcs_mode_q == FCS_32) ? 16'd4 : 16'd0);
        res.kind = KIND_EOF;
        if (uid_en_q) res.frame_uid = uid_acc;
        if (frame_bytes < fcs_len) begin
          res.status = ST_FAILED;
        end else begin
          len = frame_bytes - fcs_len;
          res.frame_length = len;
          if (fcs_mode_q == FCS_16) fcs_ok = (fcs_acc == FCS16_GOOD);
          else if (fcs_mode_q == FCS_32) fcs_ok = (fcs_acc == FCS32_GOOD);
          else fcs_ok = 1'b1;
          if (len >= buf_size_q) res.status = ST_TOO_LARGE;
          else if (!fcs_ok) res.status = ST_FAILED;
          else res.status = ST_OK;
        end
        decoded_q.push_back(res);
      end
    end else if (b == ESC_BYTE) begin
      last_byte = ESC_BYTE;
    end else begin
      d = (last_byte == ESC_BYTE) ? (b ^ ESC_XOR) : b;
      last_byte = b;
      if (rx_phase == PH_UID) begin
        if (uid_bits[3]) uid_acc[15:8] = uid_acc[15:8] | d;
        else uid_acc[7:0] = uid_acc[7:0] | d;
        uid_bits = uid_bits + 5'd8;
        if (uid_bits >= 5'd16) rx_phase = PH_DATA;
      end else begin
        if (frame_bytes < buf_size_q) begin
          res.kind = KIND_DATA;
          res.data_byte = d;
          res.byte_index = frame_bytes;
          decoded_q.push_back(res);
        end
        if (frame_bytes != 16'hFFFF) frame_bytes = frame_bytes + 16'd1;
      end
      fcs_acc = fcs_step(fcs_mode_q, fcs_acc, d);
    end
  endtask

  // one line byte transaction, optionally after an idle gap
  task automatic send_rx(input logic [7:0] b);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_line_byte(b);
    items_sent++;
  endtask

  // hold the line until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_FCS_MODE) fcs_mode_q = val[1:0];
    else if (idx == CFG_UID_ENABLE) uid_en_q = val[0];
    else if (idx == CFG_BUFFER_SIZE) buf_size_q = val;
  endtask

  // finish any open frame so that the receiver is back between frames
  task automatic close_frame();
    while (rx_phase != PH_IDLE) begin
      if (last_byte == FLAG_BYTE) send_rx(8'h41);
      else send_rx(FLAG_BYTE);
    end
  endtask

  // unused upper data bits are random
  task automatic set_config(input logic [1:0] mode, input logic uid_on, input logic [15:0] bsz);
    logic [15:0] word;
    close_frame();
    wait_drained();
    word = 16'($urandom);
    word[1:0] = mode;
    write_reg(CFG_FCS_MODE, word);
    word = 16'($urandom);
    word[0] = uid_on;
    write_reg(CFG_UID_ENABLE, word);
    write_reg(CFG_BUFFER_SIZE, bsz);
  endtask

  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    case ($urandom_range(0, 23))
      0: b = FLAG_BYTE;
      1: b = ESC_BYTE;
      2: b = FLAG_BYTE ^ ESC_XOR;
      3: b = ESC_BYTE ^ ESC_XOR;
      4: b = 8'h00;
      5: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic byte_q_t random_body(int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(random_byte());
    return q;
  endfunction

  function automatic int body_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 92) return $urandom_range(13, 40);
    return $urandom_range(41, 300);
  endfunction

  // frame for the current settings: UID, body, FCS, stuffing; optionally corrupted or escape-closed
  task automatic send_frame(input byte_q_t body, input bit corrupt, input int n_open,
                            input bit esc_close);
    byte_q_t     dec;
    logic [15:0] uid;
    logic [31:0] acc;
    logic [31:0] f;
    int          k;
    if (uid_en_q) begin
      uid = 16'($urandom);
      dec.push_back(uid[7:0]);
      dec.push_back(uid[15:8]);
    end
    foreach (body[i]) dec.push_back(body[i]);
    if (fcs_mode_q == FCS_16 || fcs_mode_q == FCS_32) begin
      acc = (fcs_mode_q == FCS_16) ? FCS16_INIT : FCS32_INIT;
      foreach (dec[i]) acc = fcs_step(fcs_mode_q, acc, dec[i]);
      f = ~acc;
      dec.push_back(f[7:0]);
      dec.push_back(f[15:8]);
      if (fcs_mode_q == FCS_32) begin
        dec.push_back(f[23:16]);
        dec.push_back(f[31:24]);
      end
    end
    if (corrupt && dec.size() > 0) begin
      k = $urandom_range(0, dec.size() - 1);
      dec[k] = dec[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    repeat (n_open) send_rx(FLAG_BYTE);
    // flag and escape must be stuffed; other bytes now and then too, except
    // those whose stuffed form would read as a flag or an escape
    foreach (dec[i]) begin
      if (dec[i] == FLAG_BYTE || dec[i] == ESC_BYTE ||
          ($urandom_range(0, 9) == 0 && dec[i] != (FLAG_BYTE ^ ESC_XOR) &&
           dec[i] != (ESC_BYTE ^ ESC_XOR))) begin
        send_rx(ESC_BYTE);
        send_rx(dec[i] ^ ESC_XOR);
      end else begin
        send_rx(dec[i]);
      end
    end
    if (esc_close) send_rx(ESC_BYTE);
    send_rx(FLAG_BYTE);
  endtask

  // ---- tests ----

  task automatic test_out_of_sync();
    send_rx(8'h00);
    send_rx(8'hFF);
  endtask

  // repeated flag, escape after escape, escape right before the closing flag
  task automatic test_escapes();
    send_rx(FLAG_BYTE);
    send_rx(FLAG_BYTE);
    send_rx(8'h41);
    send_rx(ESC_BYTE);
    send_rx(ESC_BYTE);
    send_rx(FLAG_BYTE ^ ESC_XOR);
    send_rx(ESC_BYTE);
    send_rx(FLAG_BYTE);
  endtask

  task automatic test_short_frame();
    send_rx(FLAG_BYTE);
    send_rx(8'h41);
    send_rx(FLAG_BYTE);
  endtask

  task automatic test_good_frame();
    byte_q_t body;
    body.push_back(ESC_BYTE);
    body.push_back(8'hFF);
    send_frame(body, 1'b0, 1, 1'b0);
  endtask

  // zero buffer: too large, but a too-short frame still reports failed
  task automatic test_buffer_zero();
    set_config(2'd3, 1'b0, 16'd0);
    test_short_frame();
    set_config(FCS_16, 1'b0, 16'd0);
    test_short_frame();
  endtask

  // frame that closes while the UID is still being collected
  task automatic test_uid_pending();
    set_config(FCS_32, 1'b1, 16'd256);
    send_rx(FLAG_BYTE);
    send_rx(8'h12);
    send_rx(FLAG_BYTE);
  endtask

  // frame that runs past the buffer, bytes sent back to back
  task automatic test_long_frame();
    set_config(FCS_16, 1'b0, 16'd128);
    sender_gaps = 1'b0;
    send_frame(random_body(200), 1'b0, 1, 1'b0);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned phase_end;
    int          r;
    logic [15:0] bsz;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 45) bsz = 16'($urandom_range(1, 64));
      else if (r < 62) bsz = 16'd256;
      else if (r < 72) bsz = 16'hFFFF;
      else if (r < 80) bsz = 16'd0;
      else if (r < 88) bsz = 16'd1;
      else bsz = 16'($urandom);
      set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), bsz);
      phase_end = items_sent + $urandom_range(60, 200);
      while (items_sent < phase_end && items_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_frame(random_body(body_len()), $urandom_range(0, 4) == 0,
                     ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1, 1'b0);
        end else if (r < 77) begin
          send_frame(random_body(body_len()), 1'b0, 1, 1'b1);
        end else if (r < 87) begin
          // line noise
          repeat ($urandom_range(1, 6)) send_rx(random_byte());
        end else if (r < 97) begin
          // broken frame, raw bytes, sometimes left open
          send_rx(FLAG_BYTE);
          repeat ($urandom_range(0, 8)) send_rx(random_byte());
          if ($urandom_range(0, 1)) send_rx(FLAG_BYTE);
        end else begin
          wait_drained();
        end
      end
    end
  endtask

  // ---- result checking ----

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result transaction, kind 0x%0h", kind_o);
        error_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 16'(want.kind), 16'(kind_o));
        check_field("data_byte", 16'(want.data_byte), 16'(data_byte_o));
        check_field("byte_index", want.byte_index, byte_index_o);
        check_field("frame_length", want.frame_length, frame_length_o);
        check_field("status", 16'(want.status), 16'(status_o));
        check_field("frame_uid", want.frame_uid, frame_uid_o);
      end
    end
  end

  // random back-pressure on the result side, with stall-free stretches
  initial begin : result_stall_gen
    int run;
    out_stall_i <= 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk_i);
      run = result_stalls ? pick_gap() : 0;
      if (run > 0) begin
        out_stall_i <= 1'b1;
        repeat (run) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i <= 8'h00;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_FCS_MODE;
    cfg_data_i <= 16'h0000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_out_of_sync();
    test_escapes();
    test_short_frame();
    test_good_frame();
    test_buffer_zero();
    test_uid_pending();
    test_long_frame();
    test_random_traffic(RANDOM_ITEMS);

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
